### hdl/q4bd_pkg.sv
// Shared types, constants and the scale-times-nibble function of the Q4 block dequantizer.
// It depends on nothing else.
package q4bd_pkg;

    localparam int unsigned BsW = 9;
    localparam int unsigned CntW = 7;
    localparam logic [BsW-1:0] BsReset = 9'd32;
    localparam logic [31:0] F32Inf = 32'h7F80_0000;
    localparam logic [31:0] F32Quiet = 32'h0040_0000;
    localparam logic [31:0] F32DefNan = 32'h7FC0_0000;
    localparam logic [7:0] ExpRebias = 8'd112;
    localparam logic [4:0] HalfExpMax = 5'h1F;
    localparam logic [3:0] NibOffset = 4'd8;

    // Queue entry between the front and back parts.
    typedef struct packed {
        logic [15:0] scale;
        logic [7:0]  byte_val;
        logic        block_end;
        logic        stream_end;
    } t_work;

    typedef struct packed {
        logic [31:0] value_even;
        logic [31:0] value_odd;
        logic        block_end;
        logic        stream_end;
    } t_result;

    // Exact product of a half scale and (nibble - 8), as single bits; a subnormal scale gives a signed zero.
    function automatic logic [31:0] scale_times(input logic [15:0] h, input logic [3:0] nib);
        logic        hs;
        logic [4:0]  e;
        logic [9:0]  m;
        logic        ks;
        logic [3:0]  mag;
        logic        sgn;
        logic [13:0] prod;
        logic [7:0]  bexp;
        logic [22:0] frac;
        hs = h[15];
        e = h[14:10];
        m = h[9:0];
        ks = ~nib[3];
        mag = nib[3] ? (nib - NibOffset) : (NibOffset - nib);
        sgn = hs ^ ks;
        prod = 14'({1'b1, m}) * 14'(mag);
        // normalize: leading one sits at bit 10..13
        if (prod[13]) begin
            bexp = 8'(e) + ExpRebias + 8'd3;
            frac = {prod[12:0], 10'd0};
        end else if (prod[12]) begin
            bexp = 8'(e) + ExpRebias + 8'd2;
            frac = {prod[11:0], 11'd0};
        end else if (prod[11]) begin
            bexp = 8'(e) + ExpRebias + 8'd1;
            frac = {prod[10:0], 12'd0};
        end else begin
            bexp = 8'(e) + ExpRebias;
            frac = {prod[9:0], 13'd0};
        end
        if (e == HalfExpMax) begin
            if (m != 10'd0) begin
                scale_times = {hs, 31'd0} | F32Inf | {9'd0, m, 13'd0} | F32Quiet;
            end else if (mag == 4'd0) begin
                scale_times = F32DefNan;
            end else begin
                scale_times = {sgn, 31'd0} | F32Inf;
            end
        end else if (e == 5'd0 || mag == 4'd0) begin
            scale_times = {sgn, 31'd0};
        end else begin
            scale_times = {sgn, bexp, frac};
        end
    endfunction

endpackage

### hdl/q4_block_dequantizer.sv
// Top level of the Q4 block dequantizer: config register, front and back parts.
// Depends on q4bd_pkg, q4bd_front, q4bd_back.
// Takes one packed byte per cycle while tready is high, gives two single-precision
// weights per byte, one result per cycle while the receiver is ready; a result
// passes through one queue entry and the output register of the multiply before
// it is offered. A stalled receiver backs up two queued requests before tready
// drops. The scale is latched on the first byte of each block; tlast closes a block.
module q4_block_dequantizer
    import q4bd_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [BsW-1:0] i_cfg_data,    // weights per block
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [23:0]    s_axis_tdata,  // scale_half, packed_byte
    input  logic           s_axis_tlast,  // last_byte
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [63:0]    m_axis_tdata,  // value_even, value_odd
    output logic           m_axis_tuser,  // block_end
    output logic           m_axis_tlast   // stream_end
);

    logic [BsW-1:0] r_bs;
    logic           push;
    logic           full;
    t_work          work;
    t_result        res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs <= BsReset;
        end else if (i_cfg_valid) begin
            r_bs <= i_cfg_data;
        end
    end

    q4bd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_blk_len   (r_bs),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_scale     (s_axis_tdata[15:0]),
        .i_byte      (s_axis_tdata[23:16]),
        .i_last      (s_axis_tlast),
        .o_push      (push),
        .o_work      (work),
        .i_full      (full)
    );

    q4bd_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_work (work),
        .o_full (full),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_res  (res)
    );

    assign m_axis_tdata = {res.value_odd, res.value_even};
    assign m_axis_tuser = res.block_end;
    assign m_axis_tlast = res.stream_end;

endmodule

### hdl/q4bd_front.sv
// Front part: accepts bytes, latches block scales, counts bytes within a block.
// Depends on q4bd_pkg.
module q4bd_front
    import q4bd_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [BsW-1:0] i_blk_len,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [15:0]    i_scale,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    output logic           o_push,
    output t_work          o_work,
    input  logic           i_full
);

    logic [CntW-1:0] r_cnt;
    logic [CntW-1:0] n_cnt;
    logic [15:0]     r_scale;
    logic [15:0]     scale_now;
    logic [7:0]      bytes;
    logic [7:0]      bytes_m1;
    logic            blk_end;

    always_comb begin
        bytes = i_blk_len[8:1];
        if (i_blk_len[8:1] == 8'd0) begin
            bytes = 8'd1;
        end else if (i_blk_len[8:1] > 8'd128) begin
            bytes = 8'd128;
        end
        bytes_m1 = bytes - 8'd1;
        scale_now = (r_cnt == '0) ? i_scale : r_scale;
        blk_end = (8'(r_cnt) >= bytes_m1) || i_last;
        n_cnt = blk_end ? '0 : r_cnt + CntW'(1);
    end

    assign o_ready = ~i_full;
    assign o_push = i_valid & ~i_full;
    assign o_work = '{scale: scale_now, byte_val: i_byte, block_end: blk_end,
                      stream_end: i_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_scale <= '0;
        end else if (o_push) begin
            r_cnt <= n_cnt;
            r_scale <= scale_now;
        end
    end

endmodule

### hdl/q4bd_back.sv
// Back part: two-entry queue, then the exact multiply into a registered output.
// Depends on q4bd_pkg.
module q4bd_back
    import q4bd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_work   i_work,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    t_work       r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        r_ov;
    t_result     r_res;
    logic        pop;
    t_work       head;

    assign o_full = (r_cnt == 2'd2);
    assign head = r_q[r_rp];
    // advance when the output register is empty or being taken
    assign pop = (r_cnt != 2'd0) && (!r_ov || i_ready);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_work;
        end
        if (pop) begin
            r_res.value_even <= scale_times(head.scale, head.byte_val[3:0]);
            r_res.value_odd <= scale_times(head.scale, head.byte_val[7:4]);
            r_res.block_end <= head.block_end;
            r_res.stream_end <= head.stream_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
            r_ov <= 1'b0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop);
            if (pop) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end

    assign o_valid = r_ov;
    assign o_res = r_res;

endmodule

### tb/sv/q4_block_dequantizer_tb.sv
// Testbench of the Q4 block dequantizer: directed and random byte streams with random
// idling on both sides, checked against an in-bench predictor. Depends on q4bd_pkg and the RTL.
module q4_block_dequantizer_tb;
    import q4bd_pkg::*;

    typedef struct {
        logic [31:0] value_even;
        logic [31:0] value_odd;
        logic        block_end;
        logic        stream_end;
    } t_weights;

    int unsigned n_errors = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        n_errors++;
    endtask

    class weight_board;
        logic [8:0]  blk_len;
        logic [6:0]  byte_pos;
        logic [15:0] latched_scale;
        t_weights    pending[$];
        int unsigned n_checked;

        function new();
            blk_len = 9'd32;
            byte_pos = '0;
            latched_scale = '0;
            n_checked = 0;
        endfunction

        function automatic logic [31:0] mul_half(logic [15:0] h, int k);
            logic        hs;
            logic [4:0]  e;
            logic [9:0]  m;
            logic [31:0] sgn, prod, bexp;
            int          mag, p;
            hs = h[15];
            e = h[14:10];
            m = h[9:0];
            mag = (k < 0) ? -k : k;
            sgn = {hs ^ (k < 0), 31'd0};
            if (e == 5'h1F) begin
                if (m != 0)
                    return {hs, 31'd0} | 32'h7F80_0000 | {9'd0, m, 13'd0} | 32'h0040_0000;
                if (mag == 0) return 32'h7FC0_0000;
                return sgn | 32'h7F80_0000;
            end
            if (e == 0 || mag == 0) return sgn;
            prod = {21'd1, m} * mag;
            p = 10;
            while (p < 13 && (prod >> (p + 1)) != 0) p++;
            bexp = e + 112 - 10 + p;
            return sgn | (bexp << 23) | ((prod << (23 - p)) & 32'h007F_FFFF);
        endfunction

        function void note_request(logic [15:0] scale, logic [7:0] b, logic last);
            int       bytes;
            t_weights w;
            bytes = blk_len >> 1;
            if (bytes == 0) bytes = 1;
            if (bytes > 128) bytes = 128;
            if (byte_pos == 0) latched_scale = scale;
            w.value_even = mul_half(latched_scale, int'(b[3:0]) - 8);
            w.value_odd = mul_half(latched_scale, int'(b[7:4]) - 8);
            w.block_end = (int'(byte_pos) >= bytes - 1) || last;
            w.stream_end = last;
            byte_pos = w.block_end ? 7'd0 : byte_pos + 7'd1;
            pending.push_back(w);
        endfunction

        task check_result(logic [63:0] d, logic be, logic se);
            t_weights w;
            if (pending.size() == 0) begin
                report("unexpected result", d[31:0], 0);
                return;
            end
            w = pending.pop_front();
            n_checked++;
            if (d[31:0] !== w.value_even) report("value_even", d[31:0], w.value_even);
            if (d[63:32] !== w.value_odd) report("value_odd", d[63:32], w.value_odd);
            if (be !== w.block_end) report("block_end", be, w.block_end);
            if (se !== w.stream_end) report("stream_end", se, w.stream_end);
        endtask
    endclass

    weight_board board = new();

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_valid = 0;
    logic [8:0]  i_cfg_data = '0;
    logic        o_cfg_ready;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    int          hold_off = 0;
    bit          stall_sink = 0;
    bit          stall_used = 0;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    q4_block_dequantizer dut (.*);

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    // sink: random ready, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        if (stall_sink && !stall_used) begin
            stall_used <= 1;
            hold_off <= 200;
            m_axis_tready <= 0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_byte(input logic [15:0] scale, input logic [7:0] b, input logic last);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {b, scale};
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_request(scale, b, last);
    endtask

    task automatic write_blk_len(input logic [8:0] v);
        int guard;
        guard = 0;
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.blk_len = v;
        i_cfg_valid <= 0;
    endtask

    function automatic logic [15:0] rand_scale();
        case ($urandom_range(0, 9))
            0: return {1'($urandom_range(0, 1)), 5'h1F, 10'd0};
            1: return {1'($urandom_range(0, 1)), 5'h1F, 10'($urandom_range(1, 1023))};
            2: return {1'($urandom_range(0, 1)), 5'h00, 10'($urandom())};
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        logic [8:0] sizes[6];
        logic [15:0] dir_scales[6];
        int n_sent;
        sizes = '{9'd2, 9'd256, 9'd8, 9'd3, 9'd511, 9'd0};
        dir_scales = '{16'h3C00, 16'hFBFF, 16'h7C00, 16'hFC00, 16'h7D55, 16'h83FF};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: extreme scales, nibbles 0, 7, 8 and 15, infinity and NaN, subnormal, early tlast
        for (int i = 0; i < 6; i++) begin
            send_byte(dir_scales[i], 8'h08, 0);
            send_byte(16'h0000, 8'hF0, 0);
            send_byte(16'h0000, 8'h7F, i == 5);
        end
        write_blk_len(9'd4);
        for (int i = 0; i < 5; i++) send_byte(16'h4000 + i, 8'(i * 51), 0);
        n_sent = 23;
        for (int s = 0; s < 6; s++) begin
            write_blk_len(sizes[s]);
            for (int i = 0; i < 110; i++) begin
                if (s == 2 && i == 10) stall_sink = 1;
                if (s == 2 && i == 60) stall_sink = 0;
                send_byte(rand_scale(), 8'($urandom()), $urandom_range(0, 40) == 0);
                n_sent++;
            end
        end
        write_blk_len(9'd5);
        for (int i = 0; i < 40; i++) send_byte(rand_scale(), 8'($urandom()), i == 39);
        n_sent += 40;
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("sent %0d bytes over nine block settings, checked %0d results", n_sent,
                 board.n_checked);
        if (n_errors == 0) begin
            $display("[q4_block_dequantizer] OK");
        end else begin
            $display("[q4_block_dequantizer] ERROR");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("[q4_block_dequantizer] ERROR");
        $finish;
    end
endmodule
